### rtl/nfsa_pkg.sv
// ----------------------------------------------------------------------------
// nfsa_pkg
// Shared types and codes for the next-fit slot allocator.
// ----------------------------------------------------------------------------
package nfsa_pkg;

   // occupancy bitmap word
   localparam int WORD_W = 32;
   localparam int BIT_W  = 5;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_LOOKUP = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;

   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_HELD = 2'd1;
   localparam logic [1:0] STAT_FULL = 2'd2;
   localparam logic [1:0] STAT_MISS = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL
   } nfsa_state_type;

endpackage

### rtl/nfsa_if.sv
// ----------------------------------------------------------------------------
// nfsa_if
// Request and response channels of the next-fit slot allocator.
// ----------------------------------------------------------------------------
interface nfsa_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [31:0] handle;
   logic        holds_id;
   logic [15:0] slot_id;

   modport source (output valid, opcode, handle, holds_id, slot_id, input ready);
   modport sink   (input valid, opcode, handle, holds_id, slot_id, output ready);
endinterface

interface nfsa_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [11:0] assigned_slot;
   logic [31:0] found_handle;

   modport source (output valid, status, assigned_slot, found_handle, input ready);
   modport sink   (input valid, status, assigned_slot, found_handle, output ready);
endinterface

### rtl/next_fit_slot_allocator.sv
// Each request passes through the read and evaluate states once it is
// accepted; an insert passes through them again for each further bitmap
// word examined, as the bitmap has a single read port.
// One request is in flight at a time; the next is taken in the cycle its
// response appears.
// Reset clears the row valid bits of the bitmap and the search pointer;
// the handle store is not cleared.
// ----------------------------------------------------------------------------
// next_fit_slot_allocator
// Slot table that hands out IDs by next-fit search over an occupancy bitmap.
// ----------------------------------------------------------------------------
module next_fit_slot_allocator
   import nfsa_pkg::*;
#(
   parameter int SLOTS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   nfsa_req_if.sink    req_chan,
   nfsa_rsp_if.source  rsp_chan
);

   localparam int NW         = (SLOTS + WORD_W - 1) / WORD_W;
   localparam int WIDX_W     = (NW > 1) ? $clog2(NW) : 1;
   localparam int IDX_W      = $clog2(SLOTS);
   localparam int SLOT_EXT_W = WIDX_W + BIT_W;
   localparam int CNT_W      = $clog2(NW + 1);

   // memories
   logic [WORD_W-1:0] occ_mem [NW];
   logic [31:0]       hnd_mem [SLOTS];
   logic              row_valid_ff [NW];

   logic [WORD_W-1:0] occ_rd_ff;
   logic              occ_rdv_ff;
   logic [31:0]       hnd_rd_ff;

   logic              occ_we;
   logic [WIDX_W-1:0] occ_waddr;
   logic [WORD_W-1:0] occ_wdata;
   logic [WIDX_W-1:0] occ_raddr;
   logic              hnd_we;
   logic [IDX_W-1:0]  hnd_waddr;

   nfsa_state_type    state_ff, state_in;
   logic [IDX_W-1:0]  start_ff, start_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [11:0]       rsp_slot_ff, rsp_slot_in;
   logic [31:0]       rsp_handle_ff, rsp_handle_in;

   logic [1:0]        op_ff;
   logic [31:0]       handle_ff;
   logic              holds_ff;
   logic [15:0]       sid_ff;
   logic [WIDX_W-1:0] cw_ff, cw_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   logic                  accept;
   logic                  out_free;
   logic                  finish;
   logic [WORD_W-1:0]     occ_word;
   logic [WORD_W-1:0]     range_mask;
   logic [WORD_W-1:0]     pass_mask;
   logic [WORD_W-1:0]     free_w;
   logic [WORD_W-1:0]     one_hot;
   logic [BIT_W-1:0]      pos;
   logic                  found;
   logic [SLOT_EXT_W-1:0] slot_ext;
   logic [SLOT_EXT_W-1:0] start_ext;
   logic                  sid_in_range;
   logic [WIDX_W-1:0]     sid_word;

   assign accept         = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.assigned_slot = rsp_slot_ff;
   assign rsp_chan.found_handle  = rsp_handle_ff;

   assign sid_in_range = (sid_ff < 16'(SLOTS));
   assign sid_word     = sid_ff[WIDX_W+BIT_W-1:BIT_W];
   assign start_ext    = SLOT_EXT_W'(start_ff);
   assign occ_raddr    = (op_ff == OP_INSERT) ? cw_ff : sid_word;

   // rows never written read as all free
   assign occ_word = occ_rdv_ff ? occ_rd_ff : '0;

   always_comb begin
      for (int i = 0; i < WORD_W; i++) begin
         range_mask[i] = ((SLOT_EXT_W+1)'({cw_ff, BIT_W'(i)}) < (SLOT_EXT_W+1)'(SLOTS));
         if (cnt_ff == '0) begin
            pass_mask[i] = (BIT_W'(i) >= start_ext[BIT_W-1:0]);
         end else if (cnt_ff == CNT_W'(NW)) begin
            pass_mask[i] = (BIT_W'(i) < start_ext[BIT_W-1:0]);
         end else begin
            pass_mask[i] = 1'b1;
         end
      end
   end

   // lowest free bit
   always_comb begin
      free_w  = ~occ_word & range_mask & pass_mask;
      one_hot = free_w & (~free_w + 1'b1);
      found   = |free_w;
      pos     = '0;
      for (int i = 0; i < WORD_W; i++) begin
         if (one_hot[i]) begin
            pos = pos | BIT_W'(i);
         end
      end
      slot_ext = {cw_ff, pos};
   end

   always_comb begin
      state_in      = state_ff;
      start_in      = start_ff;
      cw_in         = cw_ff;
      cnt_in        = cnt_ff;
      finish        = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_handle_in = rsp_handle_ff;
      occ_we        = 1'b0;
      occ_waddr     = occ_raddr;
      occ_wdata     = occ_word;
      hnd_we        = 1'b0;
      hnd_waddr     = IDX_W'(slot_ext);

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cw_in    = start_ext[SLOT_EXT_W-1:BIT_W];
               cnt_in   = '0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            rsp_status_in = STAT_OK;
            rsp_slot_in   = '0;
            rsp_handle_in = '0;
            case (op_ff)
               OP_INSERT: begin
                  if (holds_ff) begin
                     rsp_status_in = STAT_HELD;
                     finish        = out_free;
                  end else if (found) begin
                     rsp_slot_in = 12'(slot_ext);
                     finish      = out_free;
                     occ_we      = out_free;
                     hnd_we      = out_free;
                     occ_wdata   = occ_word | one_hot;
                     if (out_free) begin
                        if (slot_ext == SLOT_EXT_W'(SLOTS - 1)) begin
                           start_in = '0;
                        end else begin
                           start_in = IDX_W'(slot_ext + 1'b1);
                        end
                     end
                  end else if (cnt_ff == CNT_W'(NW)) begin
                     rsp_status_in = STAT_FULL;
                     finish        = out_free;
                  end else begin
                     // move on to the next bitmap word, with wrap
                     cw_in    = (cw_ff == WIDX_W'(NW - 1)) ? '0 : cw_ff + 1'b1;
                     cnt_in   = cnt_ff + 1'b1;
                     state_in = ST_READ;
                  end
               end
               OP_LOOKUP: begin
                  finish = out_free;
                  if (sid_in_range && occ_word[sid_ff[BIT_W-1:0]]) begin
                     rsp_handle_in = hnd_rd_ff;
                  end else begin
                     rsp_status_in = STAT_MISS;
                  end
               end
               OP_DELETE: begin
                  finish    = out_free;
                  occ_we    = out_free && holds_ff && sid_in_range;
                  occ_wdata = occ_word & ~(WORD_W'(1) << sid_ff[BIT_W-1:0]);
               end
               default: begin
                  finish = out_free;
               end
            endcase
            if (finish) begin
               state_in = ST_IDLE;
            end else begin
               // a response still waiting keeps its payload
               rsp_status_in = rsp_status_ff;
               rsp_slot_in   = rsp_slot_ff;
               rsp_handle_in = rsp_handle_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (finish) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NW; i++) begin
            row_valid_ff[i] <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
         if (occ_we) begin
            row_valid_ff[occ_waddr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_handle_ff <= rsp_handle_in;
      cw_ff         <= cw_in;
      cnt_ff        <= cnt_in;
      if (accept) begin
         op_ff     <= req_chan.opcode;
         handle_ff <= req_chan.handle;
         holds_ff  <= req_chan.holds_id;
         sid_ff    <= req_chan.slot_id;
      end
   end

   // occupancy bitmap
   always_ff @(posedge clock) begin
      if (occ_we) begin
         occ_mem[occ_waddr] <= occ_wdata;
      end
      occ_rd_ff  <= occ_mem[occ_raddr];
      occ_rdv_ff <= row_valid_ff[occ_raddr];
   end

   // handle store
   always_ff @(posedge clock) begin
      if (hnd_we) begin
         hnd_mem[hnd_waddr] <= handle_ff;
      end
      hnd_rd_ff <= hnd_mem[sid_ff[IDX_W-1:0]];
   end

`ifndef NO_ASSERTIONS
   a_start_range: assert property (@(posedge clock) disable iff (reset)
      (SLOT_EXT_W+1)'(start_ff) < (SLOT_EXT_W+1)'(SLOTS))
      else $error("search pointer out of range");

   a_rsp_from_eval: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EVAL))
      else $error("response raised outside evaluation");

   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != STAT_OK |-> rsp_slot_ff == '0 && rsp_handle_ff == '0)
      else $error("nonzero payload on failed request");

   a_insert_slot: assert property (@(posedge clock) disable iff (reset)
      hnd_we |-> (SLOT_EXT_W+1)'(slot_ext) < (SLOT_EXT_W+1)'(SLOTS) && occ_we)
      else $error("insert into slot beyond table");
`endif

endmodule
